/* rtl/v210u_pkg.sv */
// v210u_pkg: shared types and constants of the v210 group unpacker
`timescale 1ns / 1ps

package v210u_pkg;

    localparam int SAMPLE_W         = 10;
    localparam int CFG_W            = 13;
    // position width, holds every configured value and every pixel position
    localparam int XW               = CFG_W + 1;
    localparam int APB_DATA_W       = 32;
    localparam int APB_ADDR_W       = 3;
    localparam int PIXELS_PER_GROUP = 6;
    localparam int BLOCK_PIXELS     = 48;
    localparam int GROUPS_PER_BLOCK = 8;
    localparam int MIN_WIDTH        = 2;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic REG_LINE_WIDTH = 1'b0;
    localparam logic REG_LINE_COUNT = 1'b1;

    localparam logic [CFG_W-1:0] LINE_WIDTH_RESET = CFG_W'(1920);
    localparam logic [CFG_W-1:0] LINE_COUNT_RESET = CFG_W'(1080);

    // pair codes within a group
    localparam logic [1:0] PAIR_FIRST  = 2'd0;
    localparam logic [1:0] PAIR_SECOND = 2'd1;
    localparam logic [1:0] PAIR_THIRD  = 2'd2;

    // one classified group waiting for the back end
    typedef struct packed {
        logic [5:0][SAMPLE_W-1:0] luma;
        logic [2:0][SAMPLE_W-1:0] cb;
        logic [2:0][SAMPLE_W-1:0] cr;
        logic [1:0]               last_pair;
        logic                     line_end;
        logic                     frame_end;
    } entry_t;

endpackage

/* rtl/v210u_front.sv */
// v210u_front: accepts groups, tracks line position and classifies the pairs
`timescale 1ns / 1ps

module v210u_front #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_LINES = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [31:0]                word0,
    input  logic [31:0]                word1,
    input  logic [31:0]                word2,
    input  logic [31:0]                word3,
    input  logic [v210u_pkg::CFG_W-1:0] line_width,
    input  logic [v210u_pkg::CFG_W-1:0] line_count,
    input  logic                       q_full,
    output logic                       push,
    output v210u_pkg::entry_t          entry
);
    import v210u_pkg::*;

    localparam int GROUPS_MAX = ((MAX_WIDTH + BLOCK_PIXELS - 1) / BLOCK_PIXELS)
                                * GROUPS_PER_BLOCK;
    localparam int GROUP_W    = $clog2(GROUPS_MAX);
    localparam int LINE_W     = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

    logic [GROUP_W-1:0] group_reg, group_next;
    logic [LINE_W-1:0]  line_reg, line_next;
    logic [XW-1:0]      w_eff, lines_eff;
    logic [XW-1:0]      x0, x1, x2, x3;
    logic [GROUP_W:0]   group_inc;
    logic [XW-1:0]      block_px;
    logic               accept, last_line, wrap;
    logic               pv0, pv1, pv2;

    always_comb
    begin
        // clamp the registers to the supported range
        if ({1'b0, line_width} < XW'(MIN_WIDTH))
            w_eff = XW'(MIN_WIDTH);
        else if ({1'b0, line_width} > XW'(MAX_WIDTH))
            w_eff = XW'(MAX_WIDTH);
        else
            w_eff = {1'b0, line_width};

        if (line_count == '0)
            lines_eff = XW'(1);
        else if ({1'b0, line_count} > XW'(MAX_LINES))
            lines_eff = XW'(MAX_LINES);
        else
            lines_eff = {1'b0, line_count};

        in_ready  = !q_full;
        accept    = in_valid && in_ready;
        last_line = XW'(line_reg) >= (lines_eff - XW'(1));

        x0  = XW'(group_reg) * XW'(PIXELS_PER_GROUP);
        x1  = x0 + XW'(2);
        x2  = x0 + XW'(4);
        x3  = x0 + XW'(6);
        pv0 = x0 < w_eff;
        pv1 = x1 < w_eff;
        pv2 = x2 < w_eff;

        // last group of the line once the next group starts a block past the width
        group_inc = (GROUP_W + 1)'(group_reg) + (GROUP_W + 1)'(1);
        block_px  = XW'(group_inc >> $clog2(GROUPS_PER_BLOCK)) * XW'(BLOCK_PIXELS);
        wrap      = block_px >= w_eff;

        group_next = group_reg;
        line_next  = line_reg;
        if (accept)
        begin
            if (wrap)
            begin
                group_next = '0;
                line_next  = last_line ? '0 : line_reg + LINE_W'(1);
            end
            else
            begin
                group_next = group_reg + GROUP_W'(1);
            end
        end

        push = accept && pv0;

        entry.cb[0]   = word0[9:0];
        entry.luma[0] = word0[19:10];
        entry.cr[0]   = word0[29:20];
        entry.luma[1] = word1[9:0];
        entry.cb[1]   = word1[19:10];
        entry.luma[2] = word1[29:20];
        entry.cr[1]   = word2[9:0];
        entry.luma[3] = word2[19:10];
        entry.cb[2]   = word2[29:20];
        entry.luma[4] = word3[9:0];
        entry.cr[2]   = word3[19:10];
        entry.luma[5] = word3[29:20];

        if (pv2)
            entry.last_pair = PAIR_THIRD;
        else if (pv1)
            entry.last_pair = PAIR_SECOND;
        else
            entry.last_pair = PAIR_FIRST;
        // the final pair ends the line unless all three fit with room to spare
        entry.line_end  = pv2 ? (x3 >= w_eff) : 1'b1;
        entry.frame_end = entry.line_end && last_line;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg <= '0;
            line_reg  <= '0;
        end
        else
        begin
            group_reg <= group_next;
            line_reg  <= line_next;
        end
    end

endmodule

/* rtl/v210u_queue.sv */
// v210u_queue: short queue of classified groups between front and back
`timescale 1ns / 1ps

module v210u_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  v210u_pkg::entry_t push_entry,
    input  logic              pop,
    output v210u_pkg::entry_t head,
    output logic              empty,
    output logic              full
);
    import v210u_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        empty       = count_reg == '0;
        full        = count_reg == CNT_W'(QUEUE_DEPTH);
        head        = mem_reg[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

/* rtl/v210u_back.sv */
// v210u_back: steps through the pairs of the head group, one pair per cycle unless the output stalls
`timescale 1ns / 1ps

module v210u_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  v210u_pkg::entry_t                   head,
    input  logic                                empty,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [v210u_pkg::SAMPLE_W-1:0]      luma_first,
    output logic [v210u_pkg::SAMPLE_W-1:0]      luma_second,
    output logic [v210u_pkg::SAMPLE_W-1:0]      chroma_blue,
    output logic [v210u_pkg::SAMPLE_W-1:0]      chroma_red,
    output logic                                last_of_item,
    output logic                                line_end,
    output logic                                frame_end
);
    import v210u_pkg::*;

    logic [1:0]          pair_reg, pair_next;
    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] luma_first_reg, luma_first_next;
    logic [SAMPLE_W-1:0] luma_second_reg, luma_second_next;
    logic [SAMPLE_W-1:0] chroma_blue_reg, chroma_blue_next;
    logic [SAMPLE_W-1:0] chroma_red_reg, chroma_red_next;
    logic                last_reg, last_next;
    logic                line_end_reg, line_end_next;
    logic                frame_end_reg, frame_end_next;
    logic                load, final_pair;

    always_comb
    begin
        load       = !empty && (!out_valid_reg || out_ready);
        final_pair = pair_reg == head.last_pair;
        pop        = load && final_pair;

        pair_next = pair_reg;
        if (load)
            pair_next = final_pair ? PAIR_FIRST : pair_reg + 2'd1;

        out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

        case (pair_reg)
            PAIR_FIRST:
            begin
                luma_first_next  = head.luma[0];
                luma_second_next = head.luma[1];
                chroma_blue_next = head.cb[0];
                chroma_red_next  = head.cr[0];
            end
            PAIR_SECOND:
            begin
                luma_first_next  = head.luma[2];
                luma_second_next = head.luma[3];
                chroma_blue_next = head.cb[1];
                chroma_red_next  = head.cr[1];
            end
            default:
            begin
                luma_first_next  = head.luma[4];
                luma_second_next = head.luma[5];
                chroma_blue_next = head.cb[2];
                chroma_red_next  = head.cr[2];
            end
        endcase
        last_next      = final_pair;
        line_end_next  = final_pair && head.line_end;
        frame_end_next = final_pair && head.frame_end;

        out_valid    = out_valid_reg;
        luma_first   = luma_first_reg;
        luma_second  = luma_second_reg;
        chroma_blue  = chroma_blue_reg;
        chroma_red   = chroma_red_reg;
        last_of_item = last_reg;
        line_end     = line_end_reg;
        frame_end    = frame_end_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_reg      <= PAIR_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pair_reg      <= pair_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            luma_first_reg  <= luma_first_next;
            luma_second_reg <= luma_second_next;
            chroma_blue_reg <= chroma_blue_next;
            chroma_red_reg  <= chroma_red_next;
            last_reg        <= last_next;
            line_end_reg    <= line_end_next;
            frame_end_reg   <= frame_end_next;
        end
    end

    a_pair_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (pair_reg <= head.last_pair))
        else $error("pair index past last pair of group");

    a_pair_restart: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (pair_reg == PAIR_FIRST))
        else $error("pair index not restarted after group");

    a_line_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && line_end_reg) |-> last_reg)
        else $error("line end on a pair that is not last of its group");

endmodule

/* rtl/v210_group_unpack.sv */
// v210_group_unpack: top level of the v210 group unpacker with its register port
`timescale 1ns / 1ps

// v210 group unpacker. Each input item is one 16-byte v210 group given as four
// little-endian 32-bit words (three 10-bit samples per word, bits 31:30 unused);
// each output item is one 4:2:2 pixel pair with luma of the even and odd pixel
// and the shared Cb and Cr, plus marks for the last pair of the group, the last
// visible pair of a line and the last visible pair of the frame. A pair is only
// given while its first pixel lies inside line_width, so padding groups at the
// end of a line (lines pad to 48 pixels, eight groups) give nothing but still
// advance the line position. The front end classifies a group in the cycle it is
// accepted and drops it into a four-deep queue; the back end sends one pair per
// cycle, unless out_ready stalls it, from the head of that queue through an
// output register. A full group gives three pairs through the single-pair output
// register, while padding groups are taken at the input and never queued. The
// first pair passes through the queue and then the output register. Registers
// (APB, 32-bit): line_width at 0x0 (clamped to 2..MAX_WIDTH) and line_count at
// 0x4 (clamped to 1..MAX_LINES); write them only while the block is idle.
// Out-of-range values set on the fly take effect from the next group, with the
// position counters wrapping when they sit at or beyond their new end.
module v210_group_unpack #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_LINES = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [v210u_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [v210u_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [v210u_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    // group input
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [31:0]                         word0,
    input  logic [31:0]                         word1,
    input  logic [31:0]                         word2,
    input  logic [31:0]                         word3,
    // pair output
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [v210u_pkg::SAMPLE_W-1:0]      luma_first,
    output logic [v210u_pkg::SAMPLE_W-1:0]      luma_second,
    output logic [v210u_pkg::SAMPLE_W-1:0]      chroma_blue,
    output logic [v210u_pkg::SAMPLE_W-1:0]      chroma_red,
    output logic                                last_of_item,
    output logic                                line_end,
    output logic                                frame_end
);
    import v210u_pkg::*;

    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] count_reg, count_next;
    logic             cfg_write;
    logic             reg_sel;
    entry_t           push_entry, head;
    logic             push, pop, q_empty, q_full;

    // register port, registers sit on word addresses
    always_comb
    begin
        pready     = 1'b1;
        cfg_write  = psel && penable && pwrite && pready;
        reg_sel    = paddr[2];
        width_next = width_reg;
        count_next = count_reg;
        if (cfg_write)
        begin
            case (reg_sel)
                REG_LINE_WIDTH: width_next = pwdata[CFG_W-1:0];
                REG_LINE_COUNT: count_next = pwdata[CFG_W-1:0];
                default:        width_next = width_reg;
            endcase
        end
        case (reg_sel)
            REG_LINE_WIDTH: prdata = APB_DATA_W'(width_reg);
            REG_LINE_COUNT: prdata = APB_DATA_W'(count_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= LINE_WIDTH_RESET;
            count_reg <= LINE_COUNT_RESET;
        end
        else
        begin
            width_reg <= width_next;
            count_reg <= count_next;
        end
    end

    // classify groups and keep the line position
    v210u_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_LINES (MAX_LINES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .word0      (word0),
        .word1      (word1),
        .word2      (word2),
        .word3      (word3),
        .line_width (width_reg),
        .line_count (count_reg),
        .q_full     (q_full),
        .push       (push),
        .entry      (push_entry)
    );

    // decouples group intake from pair output
    v210u_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty),
        .full       (q_full)
    );

    // one pair per cycle into the output register while out_ready allows
    v210u_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (q_empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .luma_first   (luma_first),
        .luma_second  (luma_second),
        .chroma_blue  (chroma_blue),
        .chroma_red   (chroma_red),
        .last_of_item (last_of_item),
        .line_end     (line_end),
        .frame_end    (frame_end)
    );

endmodule

/* verif/v210_group_unpack_checker.sv */
// v210_group_unpack_checker: predicts the pixel pairs of each accepted group and checks the output
`timescale 1ns / 1ps

module v210_group_unpack_checker #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_LINES = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [v210u_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [v210u_pkg::APB_DATA_W-1:0]    pwdata,
    input  logic [v210u_pkg::APB_DATA_W-1:0]    prdata,
    input  logic                                pready,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [31:0]                         word0,
    input  logic [31:0]                         word1,
    input  logic [31:0]                         word2,
    input  logic [31:0]                         word3,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [v210u_pkg::SAMPLE_W-1:0]      luma_first,
    input  logic [v210u_pkg::SAMPLE_W-1:0]      luma_second,
    input  logic [v210u_pkg::SAMPLE_W-1:0]      chroma_blue,
    input  logic [v210u_pkg::SAMPLE_W-1:0]      chroma_red,
    input  logic                                last_of_item,
    input  logic                                line_end,
    input  logic                                frame_end,
    output int                                  fail_count,
    output int                                  pending
);

    import v210u_pkg::*;

    typedef struct {
        logic [SAMPLE_W-1:0] luma_first;
        logic [SAMPLE_W-1:0] luma_second;
        logic [SAMPLE_W-1:0] chroma_blue;
        logic [SAMPLE_W-1:0] chroma_red;
        logic                last_of_item;
        logic                line_end;
        logic                frame_end;
    } pair_t;

    logic [CFG_W-1:0] width_reg = LINE_WIDTH_RESET;
    logic [CFG_W-1:0] count_reg = LINE_COUNT_RESET;
    logic [9:0]       group_pos = '0;
    logic [11:0]      line_pos  = '0;
    pair_t            expected_pairs[$];
    int               errors = 0;

    task automatic compare_field(input string field, input int want, input int seen);
        if (want != seen)
        begin
            errors++;
            $display("%0t ns: %s expected %0d, got %0d", $time, field, want, seen);
        end
    endtask

    // splits one group into its visible pairs and moves the line position on
    task automatic unpack_group(input logic [31:0] w0, input logic [31:0] w1,
                                input logic [31:0] w2, input logic [31:0] w3);
        logic [SAMPLE_W-1:0] luma [6];
        logic [SAMPLE_W-1:0] cb [3];
        logic [SAMPLE_W-1:0] cr [3];
        logic [XW-1:0]       width_used;
        logic [XW-1:0]       lines_used;
        logic [XW-1:0]       groups;
        logic [XW-1:0]       first_x;
        logic [XW-1:0]       x;
        logic                last_line;
        pair_t               p;
        width_used = XW'(width_reg);
        if (width_used < XW'(MIN_WIDTH))
            width_used = XW'(MIN_WIDTH);
        if (width_used > XW'(MAX_WIDTH))
            width_used = XW'(MAX_WIDTH);
        lines_used = XW'(count_reg);
        if (lines_used < XW'(1))
            lines_used = XW'(1);
        if (lines_used > XW'(MAX_LINES))
            lines_used = XW'(MAX_LINES);
        groups = ((width_used + XW'(BLOCK_PIXELS - 1)) / XW'(BLOCK_PIXELS))
                 * XW'(GROUPS_PER_BLOCK);
        first_x = XW'(group_pos) * XW'(PIXELS_PER_GROUP);
        last_line = XW'(line_pos) >= lines_used - XW'(1);

        cb[0] = w0[9:0];    luma[0] = w0[19:10]; cr[0] = w0[29:20];
        luma[1] = w1[9:0];  cb[1] = w1[19:10];   luma[2] = w1[29:20];
        cr[1] = w2[9:0];    luma[3] = w2[19:10]; cb[2] = w2[29:20];
        luma[4] = w3[9:0];  cr[2] = w3[19:10];   luma[5] = w3[29:20];

        for (int k = 0; k < 3; k++)
        begin
            x = first_x + XW'(2 * k);
            if (x < width_used)
            begin
                p.luma_first   = luma[2 * k];
                p.luma_second  = luma[2 * k + 1];
                p.chroma_blue  = cb[k];
                p.chroma_red   = cr[k];
                p.line_end     = (x + XW'(2)) >= width_used;
                p.last_of_item = (k == 2) || p.line_end;
                p.frame_end    = p.line_end && last_line;
                expected_pairs.push_back(p);
            end
        end

        if (XW'(group_pos) >= groups - XW'(1))
        begin
            group_pos = '0;
            line_pos = last_line ? '0 : line_pos + 1'b1;
        end
        else
        begin
            group_pos = group_pos + 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pair_t want;
        logic [CFG_W-1:0] held;
        if (!rst_n)
        begin
            width_reg = LINE_WIDTH_RESET;
            count_reg = LINE_COUNT_RESET;
            group_pos = '0;
            line_pos = '0;
            expected_pairs.delete();
            errors = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            // output first, so a pair cannot match a group accepted on the same edge
            if (out_valid && out_ready)
            begin
                if (expected_pairs.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: pair expected none, got luma %0d/%0d chroma %0d/%0d",
                             $time, luma_first, luma_second, chroma_blue, chroma_red);
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    compare_field("luma_first", want.luma_first, luma_first);
                    compare_field("luma_second", want.luma_second, luma_second);
                    compare_field("chroma_blue", want.chroma_blue, chroma_blue);
                    compare_field("chroma_red", want.chroma_red, chroma_red);
                    compare_field("last_of_item", want.last_of_item, last_of_item);
                    compare_field("line_end", want.line_end, line_end);
                    compare_field("frame_end", want.frame_end, frame_end);
                end
            end
            if (in_valid && in_ready)
                unpack_group(word0, word1, word2, word3);
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[APB_ADDR_W-1:2] == REG_LINE_WIDTH)
                        width_reg = pwdata[CFG_W-1:0];
                    else
                        count_reg = pwdata[CFG_W-1:0];
                end
                else
                begin
                    held = (paddr[APB_ADDR_W-1:2] == REG_LINE_WIDTH) ? width_reg : count_reg;
                    compare_field("prdata", int'(held), int'(prdata));
                end
            end
            fail_count <= errors;
            pending <= expected_pairs.size();
        end
    end

endmodule

/* verif/v210_group_unpack_tb.sv */
// v210_group_unpack_tb: stimulus, register set-up and verdict for the v210 group unpacker
`timescale 1ns / 1ps

module v210_group_unpack_tb;

    import v210u_pkg::*;

    localparam int MAX_WIDTH = 4096;
    localparam int MAX_LINES = 4096;

    // byte addresses of the two format registers
    localparam logic [APB_ADDR_W-1:0] ADDR_LINE_WIDTH = {REG_LINE_WIDTH, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_LINE_COUNT = {REG_LINE_COUNT, 2'b00};

    // margin after the queue of four and the output register have drained
    localparam int SETTLE_CYCLES = 16;
    // long enough for the group queue to fill and push back on the input
    localparam int LONG_HOLD     = 200;
    localparam int ITEMS_PER_PHASE = 38;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr = '0;
    logic [APB_DATA_W-1:0]   pwdata = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [31:0]             word0 = '0;
    logic [31:0]             word1 = '0;
    logic [31:0]             word2 = '0;
    logic [31:0]             word3 = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [SAMPLE_W-1:0]     luma_first;
    logic [SAMPLE_W-1:0]     luma_second;
    logic [SAMPLE_W-1:0]     chroma_blue;
    logic [SAMPLE_W-1:0]     chroma_red;
    logic                    last_of_item;
    logic                    line_end;
    logic                    frame_end;

    int fail_count;
    int pending;

    // idling odds in percent, changed per phase
    int gap_pct = 0;
    int stall_pct = 0;

    // long receiver hold-offs: the stimulus bumps the request count, the
    // receiver process notices and counts the stretch out by itself
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;

    v210_group_unpack #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_LINES (MAX_LINES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .word0        (word0),
        .word1        (word1),
        .word2        (word2),
        .word3        (word3),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .luma_first   (luma_first),
        .luma_second  (luma_second),
        .chroma_blue  (chroma_blue),
        .chroma_red   (chroma_red),
        .last_of_item (last_of_item),
        .line_end     (line_end),
        .frame_end    (frame_end)
    );

    // watches both channels and the register port, predicts and compares
    v210_group_unpack_checker #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_LINES (MAX_LINES)
    ) pair_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .word0        (word0),
        .word1        (word1),
        .word2        (word2),
        .word3        (word3),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .luma_first   (luma_first),
        .luma_second  (luma_second),
        .chroma_blue  (chroma_blue),
        .chroma_red   (chroma_red),
        .last_of_item (last_of_item),
        .line_end     (line_end),
        .frame_end    (frame_end),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_requests != holds_served)
        begin
            holds_served <= hold_requests;
            hold_left <= LONG_HOLD;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99, 0) >= stall_pct);
        end
    end

    // offers one group, after any random gap, and returns on the edge that
    // accepts it with valid still high, so back-to-back items never drop valid
    task automatic offer_group(input logic [31:0] w0, input logic [31:0] w1,
                               input logic [31:0] w2, input logic [31:0] w3);
        while ($urandom_range(99, 0) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        word0 <= w0;
        word1 <= w1;
        word2 <= w2;
        word3 <= w3;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic offer_random_groups(input int count);
        repeat (count)
            offer_group($urandom(), $urandom(), $urandom(), $urandom());
    endtask

    // one register access: setup cycle, then access cycle (pready is always high)
    task automatic reg_access(input logic write, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // stop offering, let every predicted pair arrive, then leave a few
    // spare cycles before the registers change
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // new line format while idle; junk in the upper data bits must be dropped,
    // and both registers are read back
    task automatic set_format(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] count);
        settle();
        reg_access(1'b1, ADDR_LINE_WIDTH, {(APB_DATA_W - CFG_W)'($urandom()), width});
        reg_access(1'b1, ADDR_LINE_COUNT, {(APB_DATA_W - CFG_W)'($urandom()), count});
        reg_access(1'b0, ADDR_LINE_WIDTH, '0);
        reg_access(1'b0, ADDR_LINE_COUNT, '0);
    endtask

    initial
    begin
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] count;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset format (1920 x 1080): all-zero, all-one and alternating groups,
        // every sample bit and the unused top bits both ways
        offer_group('0, '0, '0, '0);
        offer_group('1, '1, '1, '1);
        offer_group(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        offer_group(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);

        // widest line and most lines, both above the clamp
        set_format(13'h1FFF, 13'h1FFF);
        offer_random_groups(4);

        // width 0 acts as 2, count 0 as one line; the group position is now
        // past the shorter line so it wraps on the next group, then padding
        set_format('0, '0);
        offer_random_groups(8);

        // odd width: the last pair keeps both lumas; two lines so the second
        // line's end is also the frame end
        set_format(13'd7, 13'd2);
        offer_random_groups(9);

        // random phases: no idling, sender idle, receiver stalling, both
        for (int k = 0; k < 8; k++)
        begin
            settle();
            case (k / 2)
                0:
                begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct = 79;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct = 0;
                    stall_pct = 79;
                end
                default:
                begin
                    gap_pct = 38;
                    stall_pct = 38;
                end
            endcase
            case (k)
                0:
                begin
                    width = CFG_W'(MIN_WIDTH);
                    count = CFG_W'(1);
                end
                5:
                begin
                    width = CFG_W'($urandom_range(8191, MAX_WIDTH + 1));
                    count = '0;
                end
                7:
                begin
                    width = CFG_W'(MAX_WIDTH);
                    count = CFG_W'(MAX_LINES);
                end
                default:
                begin
                    width = CFG_W'($urandom_range(130, 2));
                    count = CFG_W'($urandom_range(4, 1));
                end
            endcase
            set_format(width, count);
            // back-pressure: receiver holds off while the sender keeps offering
            if (k == 1)
                hold_requests <= hold_requests + 1;
            offer_random_groups(ITEMS_PER_PHASE);
        end

        settle();
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // hard stop far beyond the slowest correct run
    initial
    begin
        #3000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* v210_group_unpack.f */
rtl/v210u_pkg.sv
rtl/v210u_front.sv
rtl/v210u_queue.sv
rtl/v210u_back.sv
rtl/v210_group_unpack.sv
verif/v210_group_unpack_checker.sv
verif/v210_group_unpack_tb.sv
